FILE: rtl/core/bsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg: bounding sphere merge shared definitions
// Widths, step counts and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package bsm_pkg;

	localparam int COORD_BITS = 32;
	localparam int RAD_BITS   = COORD_BITS - 1;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	localparam int RADI_BITS  = PROD_BITS + 2;
	localparam int ROOT_BITS  = RADI_BITS / 2;
	localparam int REM_BITS   = ROOT_BITS + 4;
	localparam int Q_BITS     = COORD_BITS - 1;
	localparam int CNT_BITS   = 6;

	localparam logic [CNT_BITS-1:0] SQ_LAST   = CNT_BITS'(3);
	localparam logic [CNT_BITS-1:0] ROOT_LAST = CNT_BITS'(ROOT_BITS - 1);
	localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(Q_BITS - 1);

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic  load;
		logic  sq_mul;
		logic  sq_acc;
		logic  root_init;
		logic  root_step;
		logic  classify;
		logic  div_step;
		logic  mul_axis;
		logic  upd_axis;
		logic  commit;
		logic  out_load;
		axis_t axis;
	} dp_cmd_t;

	typedef struct packed {
		logic skip_merge;
	} dp_sts_t;

endpackage : bsm_pkg
`default_nettype wire

FILE: rtl/core/bsm_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_dp: bounding sphere merge datapath
// Stored sphere, shared multiplier, bit-serial root and divider, result register.
// ----------------------------------------------------------------------------
module bsm_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bsm_pkg::dp_cmd_t                  cmd,
	output bsm_pkg::dp_sts_t                       sts,
	input  wire logic signed [bsm_pkg::COORD_BITS-1:0] in_x,
	input  wire logic signed [bsm_pkg::COORD_BITS-1:0] in_y,
	input  wire logic signed [bsm_pkg::COORD_BITS-1:0] in_z,
	input  wire logic [bsm_pkg::RAD_BITS-1:0]          in_radius,
	input  wire logic                              restart,
	output logic signed [bsm_pkg::COORD_BITS-1:0]      out_x,
	output logic signed [bsm_pkg::COORD_BITS-1:0]      out_y,
	output logic signed [bsm_pkg::COORD_BITS-1:0]      out_z,
	output logic [bsm_pkg::RAD_BITS-1:0]               out_radius,
	output logic                                   overlapped,
	output logic                                   already_inside,
	output logic                                   replaced
);
	import bsm_pkg::*;

	localparam logic signed [ROOT_BITS-1:0] V_MIN = -(ROOT_BITS'(1) <<< (COORD_BITS - 1));
	localparam logic signed [ROOT_BITS-1:0] V_MAX = (ROOT_BITS'(1) <<< (COORD_BITS - 1)) - 1;
	localparam logic [ROOT_BITS-1:0] RAD_MAX = ROOT_BITS'({RAD_BITS{1'b1}});

	logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic [RAD_BITS-1:0]          rin_q;
	logic                         rst_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q, cz_q;
	logic [RAD_BITS-1:0]          rs_q;
	logic [PROD_BITS-1:0]         acc_q, prod_q;
	logic [RADI_BITS-1:0]         rad_q;
	logic [ROOT_BITS-1:0]         root_q;
	logic [REM_BITS-1:0]          rem_q;
	logic [ROOT_BITS-1:0]         drem_q;
	logic [Q_BITS-1:0]            q_q;
	logic                         rneg_q, ovl_q, ins_q, rep_q;

	logic signed [COORD_BITS-1:0] c_sel, p_sel;
	logic signed [DIFF_BITS-1:0]  dx, sum_cp;
	logic [DIFF_BITS-1:0]         dx_mag, mul_b;
	logic [PROD_BITS-1:0]         prod;
	logic [REM_BITS-1:0]          rem_sh, trial;
	logic                         root_ge;
	logic [COORD_BITS-1:0]        sum_r;
	logic                         rin_ge, rs_ge, ovl_c, rep_c, ins_c;
	logic [RAD_BITS-1:0]          rdiff;
	logic [ROOT_BITS:0]           r2;
	logic                         div_ge;
	logic signed [COORD_BITS-1:0] mid;
	logic [COORD_BITS-1:0]        off;
	logic signed [ROOT_BITS-1:0]  v_raw;
	logic signed [COORD_BITS-1:0] v_cl;
	logic [ROOT_BITS:0]           nr_sum;
	logic [ROOT_BITS-1:0]         nr;
	logic [RAD_BITS-1:0]          nr_sat;

	always_comb begin
		unique case (cmd.axis)
			AXIS_X: begin
				c_sel = cx_q;
				p_sel = px_q;
			end
			AXIS_Y: begin
				c_sel = cy_q;
				p_sel = py_q;
			end
			default: begin
				c_sel = cz_q;
				p_sel = pz_q;
			end
		endcase
	end

	assign dx     = DIFF_BITS'(c_sel) - DIFF_BITS'(p_sel);
	assign sum_cp = DIFF_BITS'(c_sel) + DIFF_BITS'(p_sel);
	assign dx_mag = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
	assign mul_b  = cmd.mul_axis ? DIFF_BITS'(q_q) : dx_mag;
	assign prod   = PROD_BITS'(dx_mag) * PROD_BITS'(mul_b);

	// one root bit per step
	assign rem_sh  = {rem_q[REM_BITS-3:0], rad_q[RADI_BITS-1 -: 2]};
	assign trial   = REM_BITS'({root_q, 2'b01});
	assign root_ge = rem_sh >= trial;

	assign sum_r  = COORD_BITS'(rs_q) + COORD_BITS'(rin_q);
	assign rin_ge = rin_q >= rs_q;
	assign rs_ge  = rs_q >= rin_q;
	assign rdiff  = rin_ge ? rin_q - rs_q : rs_q - rin_q;
	assign ovl_c  = ROOT_BITS'(sum_r) >= root_q;
	assign rep_c  = rin_ge && (root_q <= ROOT_BITS'(rdiff));
	assign ins_c  = rs_ge && (root_q <= ROOT_BITS'(rdiff));
	assign sts.skip_merge = rst_q | rep_c | ins_c;

	// one quotient bit per step
	assign r2     = {drem_q, 1'b0};
	assign div_ge = r2 >= {1'b0, root_q};

	assign mid   = sum_cp[DIFF_BITS-1:1];
	assign off   = prod_q[2*COORD_BITS-1:COORD_BITS];
	assign v_raw = (dx[DIFF_BITS-1] ^ rneg_q) ? ROOT_BITS'(mid) - ROOT_BITS'(off)
	                                         : ROOT_BITS'(mid) + ROOT_BITS'(off);
	always_comb begin
		priority if (v_raw < V_MIN) begin
			v_cl = COORD_BITS'(V_MIN);
		end else if (v_raw > V_MAX) begin
			v_cl = COORD_BITS'(V_MAX);
		end else begin
			v_cl = COORD_BITS'(v_raw);
		end
	end

	assign nr_sum = (ROOT_BITS + 1)'(root_q) + (ROOT_BITS + 1)'(rs_q) + (ROOT_BITS + 1)'(rin_q);
	assign nr     = nr_sum[ROOT_BITS:1];
	assign nr_sat = (nr > RAD_MAX) ? RAD_BITS'(RAD_MAX) : RAD_BITS'(nr);

	// stored sphere
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			rs_q <= '0;
		end else begin
			if (cmd.upd_axis) begin
				unique case (cmd.axis)
					AXIS_X:  cx_q <= v_cl;
					AXIS_Y:  cy_q <= v_cl;
					default: cz_q <= v_cl;
				endcase
			end
			if (cmd.commit) begin
				if (rst_q || rep_q) begin
					cx_q <= px_q;
					cy_q <= py_q;
					cz_q <= pz_q;
					rs_q <= rin_q;
				end else if (!ins_q) begin
					rs_q <= nr_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q  <= in_x;
			py_q  <= in_y;
			pz_q  <= in_z;
			rin_q <= in_radius;
			rst_q <= restart;
			acc_q <= '0;
		end
		if (cmd.sq_mul || cmd.mul_axis) begin
			prod_q <= prod;
		end
		if (cmd.sq_acc) begin
			acc_q <= acc_q + prod_q;
		end
		if (cmd.root_init) begin
			rad_q  <= RADI_BITS'(acc_q);
			root_q <= '0;
			rem_q  <= '0;
		end
		if (cmd.root_step) begin
			rad_q  <= {rad_q[RADI_BITS-3:0], 2'b00};
			root_q <= {root_q[ROOT_BITS-2:0], root_ge};
			rem_q  <= root_ge ? rem_sh - trial : rem_sh;
		end
		if (cmd.classify) begin
			ovl_q  <= ovl_c;
			rep_q  <= rep_c;
			ins_q  <= ins_c && !rep_c;
			rneg_q <= rin_q > rs_q;
			drem_q <= ROOT_BITS'(rdiff);
			q_q    <= '0;
		end
		if (cmd.div_step) begin
			drem_q <= div_ge ? ROOT_BITS'(r2 - {1'b0, root_q}) : r2[ROOT_BITS-1:0];
			q_q    <= {q_q[Q_BITS-2:0], div_ge};
		end
		if (cmd.out_load) begin
			out_x          <= cx_q;
			out_y          <= cy_q;
			out_z          <= cz_q;
			out_radius     <= rs_q;
			overlapped     <= ovl_q & ~rst_q;
			already_inside <= ins_q & ~rst_q;
			replaced       <= rep_q & ~rst_q;
		end
	end

endmodule : bsm_dp
`default_nettype wire

FILE: rtl/core/bsm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_ctrl: bounding sphere merge controller
// Sequences squaring, root, classify, divide, per-axis merge and result handoff.
// ----------------------------------------------------------------------------
module bsm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire bsm_pkg::dp_sts_t sts,
	output bsm_pkg::dp_cmd_t      cmd
);
	import bsm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_RINIT,
		ST_ROOT,
		ST_CLASS,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_COMMIT,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.axis      = AXIS_X;
		cmd.load      = in_valid && in_ready;
		unique case (state_q)
			ST_SQ: begin
				cmd.sq_mul = cnt_q != SQ_LAST;
				cmd.sq_acc = cnt_q != '0;
				cmd.axis   = axis_t'(cnt_q[1:0]);
			end
			ST_RINIT:  cmd.root_init = 1'b1;
			ST_ROOT:   cmd.root_step = 1'b1;
			ST_CLASS:  cmd.classify  = 1'b1;
			ST_DIV:    cmd.div_step  = 1'b1;
			ST_MUL: begin
				cmd.mul_axis = 1'b1;
				cmd.axis     = axis_t'(cnt_q[1:0]);
			end
			ST_UPD: begin
				cmd.upd_axis = 1'b1;
				cmd.axis     = axis_t'(cnt_q[1:0]);
			end
			ST_COMMIT: cmd.commit   = 1'b1;
			ST_OUT:    cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the taken result unless a new one replaces it this cycle
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SQ;
						cnt_q   <= '0;
					end
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQ_LAST) begin
						state_q <= ST_RINIT;
					end
				end
				ST_RINIT: begin
					state_q <= ST_ROOT;
					cnt_q   <= '0;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ROOT_LAST) begin
						state_q <= ST_CLASS;
					end
				end
				ST_CLASS: begin
					cnt_q   <= '0;
					state_q <= sts.skip_merge ? ST_COMMIT : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: state_q <= ST_UPD;
				ST_UPD: begin
					cnt_q <= cnt_q + 1'b1;
					state_q <= (cnt_q == CNT_BITS'(AXIS_Z)) ? ST_COMMIT : ST_MUL;
				end
				ST_COMMIT: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule : bsm_ctrl
`default_nettype wire

FILE: rtl/core/bounding_sphere_merge_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounding_sphere_merge_unit: incremental bounding sphere merge, Q16.16
// Folds one input sphere per request into a running bounding sphere.
// ----------------------------------------------------------------------------
// One request at a time. A request starts with one shared 33x33 multiplier,
// used three times for the squared distance, and the bit-serial square
// root (34 steps, one root bit per cycle) that yields the center distance.
// When a real merge is needed, rather than a restart or one sphere that
// contains the other, the bit-serial divider (31 steps) forms the merge
// offset ratio and the multiplier is used three times more for the per-axis
// offsets. The next request can be accepted in the same cycle in which the
// result appears. in_ready is high only while the unit is idle. The result
// sits in its own output register, so the next request is accepted while
// the previous result still waits for out_ready; the unit stalls only if a
// new result is ready before the old one has been taken. After reset the
// stored sphere is the origin point of radius zero. With restart set the
// input becomes the new sphere and all three flags are zero.
// ----------------------------------------------------------------------------
module bounding_sphere_merge_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [bsm_pkg::COORD_BITS-1:0] in_x,
	input  wire logic signed [bsm_pkg::COORD_BITS-1:0] in_y,
	input  wire logic signed [bsm_pkg::COORD_BITS-1:0] in_z,
	input  wire logic [bsm_pkg::RAD_BITS-1:0]          in_radius,
	input  wire logic                                  restart,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [bsm_pkg::COORD_BITS-1:0]      out_x,
	output logic signed [bsm_pkg::COORD_BITS-1:0]      out_y,
	output logic signed [bsm_pkg::COORD_BITS-1:0]      out_z,
	output logic [bsm_pkg::RAD_BITS-1:0]               out_radius,
	output logic                                       overlapped,
	output logic                                       already_inside,
	output logic                                       replaced
);
	import bsm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence the request through the datapath
	bsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// hold the stored sphere and do the arithmetic
	bsm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_x           (in_x),
		.in_y           (in_y),
		.in_z           (in_z),
		.in_radius      (in_radius),
		.restart        (restart),
		.out_x          (out_x),
		.out_y          (out_y),
		.out_z          (out_z),
		.out_radius     (out_radius),
		.overlapped     (overlapped),
		.already_inside (already_inside),
		.replaced       (replaced)
	);

endmodule : bounding_sphere_merge_unit
`default_nettype wire
